[rtl/assert_macros.svh]
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define GBMM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GBMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gbmm_pkg.sv]
`timescale 1ns / 1ps
package gbmm_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_FACTOR = 16;
  localparam int ROW_LIMIT  = 4096;

  localparam int CFG_W   = 13;                   // widest register
  localparam int FAC_W   = 5;
  localparam int COST_W  = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(ROW_LIMIT);
  localparam int PH_W    = $clog2(MAX_FACTOR);
  localparam int IDX_W   = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_BLOCK_FACTOR = 2'd2,
    REG_PICK_MINIMUM = 2'd3
  } cfg_reg_t;

  // Per-item control from the raster scanner to the accumulator stage.
  typedef struct packed {
    logic [COL_W-1:0] idx;
    logic [ROW_W-1:0] row;
    logic             first;
    logic             emit;
    logic             done;
  } scan_ctrl_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [COST_W-1:0] cost;
    logic              done;
  } pool_res_t;

endpackage

[rtl/gbmm_scan.sv]
`timescale 1ns / 1ps
module gbmm_scan import gbmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [CFG_W-1:0] grid_width,
  input  logic [CFG_W-1:0] grid_height,
  input  logic [FAC_W-1:0] block_factor,
  output scan_ctrl_t       ctrl
);

  logic [COL_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [PH_W-1:0]  phase_x, phase_x_next;
  logic [PH_W-1:0]  phase_y, phase_y_next;
  logic [COL_W-1:0] block_col, block_col_next;
  logic [ROW_W-1:0] block_row, block_row_next;

  logic [CFG_W-1:0] w_eff, h_eff;
  logic [FAC_W-1:0] f_eff;
  logic row_end, last_row, x_wrap, y_wrap;

  // out-of-range register values are clamped into the legal range
  always_comb begin
    if (grid_width == '0) w_eff = CFG_W'(1);
    else if (grid_width > CFG_W'(MAX_WIDTH)) w_eff = CFG_W'(MAX_WIDTH);
    else w_eff = grid_width;
    if (grid_height == '0) h_eff = CFG_W'(1);
    else if (grid_height > CFG_W'(ROW_LIMIT)) h_eff = CFG_W'(ROW_LIMIT);
    else h_eff = grid_height;
    if (block_factor == '0) f_eff = FAC_W'(1);
    else if (block_factor > FAC_W'(MAX_FACTOR)) f_eff = FAC_W'(MAX_FACTOR);
    else f_eff = block_factor;
  end

  assign row_end  = (CFG_W'(in_col) + CFG_W'(1)) >= w_eff;
  assign last_row = (CFG_W'(in_row) + CFG_W'(1)) >= h_eff;
  assign x_wrap   = (FAC_W'(phase_x) + FAC_W'(1)) >= f_eff;
  assign y_wrap   = (FAC_W'(phase_y) + FAC_W'(1)) >= f_eff;

  always_comb begin
    ctrl.idx   = block_col;
    ctrl.row   = block_row;
    ctrl.first = (phase_x == '0) && (phase_y == '0);
    ctrl.emit  = (row_end || x_wrap) && (last_row || y_wrap);
    ctrl.done  = row_end && last_row;
  end

  always_comb begin
    in_col_next    = in_col;
    in_row_next    = in_row;
    phase_x_next   = phase_x;
    phase_y_next   = phase_y;
    block_col_next = block_col;
    block_row_next = block_row;
    if (row_end) begin
      in_col_next    = '0;
      phase_x_next   = '0;
      block_col_next = '0;
      if (last_row) begin
        in_row_next    = '0;
        phase_y_next   = '0;
        block_row_next = '0;
      end else begin
        in_row_next = in_row + ROW_W'(1);
        if (y_wrap) begin
          phase_y_next   = '0;
          block_row_next = block_row + ROW_W'(1);
        end else begin
          phase_y_next = phase_y + PH_W'(1);
        end
      end
    end else begin
      in_col_next = in_col + COL_W'(1);
      if (x_wrap) begin
        phase_x_next   = '0;
        block_col_next = block_col + COL_W'(1);
      end else begin
        phase_x_next = phase_x + PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col    <= '0;
      in_row    <= '0;
      phase_x   <= '0;
      phase_y   <= '0;
      block_col <= '0;
      block_row <= '0;
    end else if (take) begin
      in_col    <= in_col_next;
      in_row    <= in_row_next;
      phase_x   <= phase_x_next;
      phase_y   <= phase_y_next;
      block_col <= block_col_next;
      block_row <= block_row_next;
    end
  end

endmodule

[rtl/gbmm_acc.sv]
`timescale 1ns / 1ps
module gbmm_acc import gbmm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  scan_ctrl_t        ctrl,
  input  logic [COST_W-1:0] cost_in,
  input  logic              pick_minimum,
  input  logic              out_free,
  output logic              busy,
  output logic              res_load,
  output pool_res_t         res
);

  logic [COST_W-1:0] acc_mem [MAX_WIDTH];

  logic              s1_valid;
  scan_ctrl_t        s1_ctrl;
  logic [COST_W-1:0] s1_cost;
  logic              s1_min;
  logic              s1_fwd;
  logic [COST_W-1:0] rd_data;
  logic [COST_W-1:0] last_acc;

  logic              adv;
  logic              wr_en;
  logic [COST_W-1:0] old_val, acc_val;

  // a non-emitting item always moves on; an emitting one needs the result slot
  assign adv      = s1_valid && (!s1_ctrl.emit || out_free);
  assign wr_en    = adv;
  assign busy     = s1_valid && !adv;
  assign res_load = adv && s1_ctrl.emit;

  // read issued on the same edge as a write to the same column sees stale data
  assign old_val = s1_fwd ? last_acc : rd_data;

  always_comb begin
    if (s1_ctrl.first) acc_val = s1_cost;
    else if (s1_min) acc_val = (old_val < s1_cost) ? old_val : s1_cost;
    else acc_val = (old_val > s1_cost) ? old_val : s1_cost;
  end

  always_comb begin
    res.col  = s1_ctrl.idx;
    res.row  = s1_ctrl.row;
    res.cost = acc_val;
    res.done = s1_ctrl.done;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rd_data <= acc_mem[ctrl.idx];
    end
    if (wr_en) begin
      acc_mem[s1_ctrl.idx] <= acc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_acc <= acc_val;
    end
    if (take) begin
      s1_ctrl <= ctrl;
      s1_cost <= cost_in;
      s1_min  <= pick_minimum;
      s1_fwd  <= wr_en && (s1_ctrl.idx == ctrl.idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

endmodule

[rtl/grid_block_min_max_pool_top.sv]
`timescale 1ns / 1ps
// Accepted cells wait in the accumulator stage; results leave via the output register.
// Throughput: one cell per cycle unless stalled; memory is read at accept, written on advance.
// Input stalls only while a block-closing cell waits behind a stalled output item.
// Back-to-back cells of one block column are served from a forwarding register.
// Reset (rst, synchronous, active high) clears the scan counters, the pipeline valids
// and the registers to their defaults; the accumulator memory is not cleared.
module grid_block_min_max_pool_top import gbmm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  // cell stream in, raster order
  input  logic               cell_valid,
  output logic               cell_stall,
  input  logic [COST_W-1:0]  cell_cost,
  // pooled cell stream out
  output logic               pool_valid,
  input  logic               pool_stall,
  output logic [COL_W-1:0]   out_col,
  output logic [ROW_W-1:0]   out_row,
  output logic [COST_W-1:0]  reduced_cost,
  output logic               map_done
);

  // configuration registers, stored raw and clamped where used
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [FAC_W-1:0] block_factor;
  logic             pick_minimum;

  logic       take;
  logic       busy;
  logic       out_free;
  logic       res_load;
  scan_ctrl_t ctrl;
  pool_res_t  res;
  pool_res_t  out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= CFG_W'(MAX_WIDTH);
      grid_height  <= CFG_W'(ROW_LIMIT);
      block_factor <= FAC_W'(1);
      pick_minimum <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:   grid_width   <= cfg_data;
        REG_GRID_HEIGHT:  grid_height  <= cfg_data;
        REG_BLOCK_FACTOR: block_factor <= cfg_data[FAC_W-1:0];
        REG_PICK_MINIMUM: pick_minimum <= cfg_data[0];
      endcase
    end
  end

  // the accumulator stage holds a cell only when its result cannot leave
  assign cell_stall = busy;
  assign take       = cell_valid && !busy;
  assign out_free   = !pool_valid || !pool_stall;

  gbmm_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .grid_width   (grid_width),
    .grid_height  (grid_height),
    .block_factor (block_factor),
    .ctrl         (ctrl)
  );

  gbmm_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .ctrl         (ctrl),
    .cost_in      (cell_cost),
    .pick_minimum (pick_minimum),
    .out_free     (out_free),
    .busy         (busy),
    .res_load     (res_load),
    .res          (res)
  );

  // output register: holds a finished item while the next cell is being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_valid <= 1'b0;
    end else if (res_load) begin
      pool_valid <= 1'b1;
    end else if (!pool_stall) begin
      pool_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign out_col      = out_res.col;
  assign out_row      = out_res.row;
  assign reduced_cost = out_res.cost;
  assign map_done     = out_res.done;

endmodule

[rtl/gbmm_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gbmm_checker import gbmm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cell_valid,
  input logic              cell_stall,
  input logic              pool_valid,
  input logic              pool_stall,
  input logic [COST_W-1:0] reduced_cost
);

  `GBMM_ASSERT(a_out_hold, clk, rst, pool_valid && pool_stall |=> pool_valid, "item dropped")
  `GBMM_ASSERT(a_out_stable, clk, rst, pool_valid && pool_stall |=> $stable(reduced_cost), "stalled item changed")
  // input backs up only behind a blocked result
  `GBMM_ASSERT_ALWAYS(a_stall_cause, clk, cell_stall |-> pool_valid && pool_stall, "stall without blocked output")
  // with no cell in and no item out the pipeline drains; no item appears from nothing
  `GBMM_ASSERT(a_no_phantom, clk, rst, !cell_valid && !pool_valid ##1 !cell_valid && !pool_valid |=> !pool_valid, "item without input")

endmodule

bind grid_block_min_max_pool_top gbmm_checker u_gbmm_checker (
  .clk          (clk),
  .rst          (rst),
  .cell_valid   (cell_valid),
  .cell_stall   (cell_stall),
  .pool_valid   (pool_valid),
  .pool_stall   (pool_stall),
  .reduced_cost (reduced_cost)
);
